// ===== hdl/rounded_rect_pixel_shader_assert.svh =====
// Assertion macros shared by the rounded rectangle shader RTL.
// Depends on signals named clock and reset in the module that expands them.
`ifndef ROUNDED_RECT_PIXEL_SHADER_ASSERT_SVH
`define ROUNDED_RECT_PIXEL_SHADER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RRPS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrps: implication check failed");

// consequent checked a fixed number of cycles later
`define RRPS_ASSERT_DLY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("rrps: delayed check failed");

`else

`define RRPS_ASSERT_IMP(label, ante, cons)

`define RRPS_ASSERT_DLY(label, ante, n, cons)

`endif

`endif

// ===== hdl/rrps_pkg.sv =====
// Shared constants and types for the rounded rectangle pixel shader.
// No dependencies; imported by rrps_isqrt, the top level and the testbench.
package rrps_pkg;

   localparam int MAX_DIM        = 1024;
   localparam int DIST_FRAC_BITS = 8;

   localparam int COORD_W   = 10;
   localparam int DIM_W     = 11;
   localparam int RADIUS_W  = 10;
   localparam int CHAN_W    = 8;
   localparam int RGB_W     = 3 * CHAN_W;
   localparam int PIXEL_W   = 4 * CHAN_W;
   localparam int CSR_W     = RGB_W;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RECT_WIDTH,
      REG_RECT_HEIGHT,
      REG_CORNER_RADIUS,
      REG_BORDER_WIDTH,
      REG_FILL_RGB,
      REG_FILL_ALPHA,
      REG_EDGE_RGB,
      REG_EDGE_ALPHA
   } csr_reg_type;

   // signed work width for coordinate / offset arithmetic
   localparam int CW    = DIM_W + 3;
   // magnitude of a doubled corner offset (below 2*radius)
   localparam int MAG_W = RADIUS_W + 1;
   localparam int SQR_W = 2 * MAG_W;
   localparam int D2_W  = SQR_W + 1;

   // square root of D2 << SQ_SHIFT, one result bit per step
   localparam int SQ_SHIFT   = 2 * DIST_FRAC_BITS - 2;
   localparam int SQ_ITER    = (D2_W + SQ_SHIFT + 1) / 2;
   localparam int RADICAND_W = 2 * SQ_ITER;
   localparam int ROOT_W     = SQ_ITER;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQ_STEPS   = 2;
   localparam int SQ_STAGES  = (SQ_ITER + SQ_STEPS - 1) / SQ_STEPS;

   // offset stage, square stage, sum stage, root stages, shade stage, output
   localparam int PIPE_LAT = SQ_STAGES + 5;

   localparam int COV_W = DIST_FRAC_BITS + 1;

   typedef struct packed {
      logic valid;
      logic outside;
      logic corner;
      logic on_border;
   } pix_tag_type;

endpackage

// ===== hdl/rrps_isqrt.sv =====
// Pipelined integer square root, SQ_STEPS result bits per stage.
// Depends on rrps_pkg; carries a pixel tag alongside the data.
`include "rounded_rect_pixel_shader_assert.svh"

module rrps_isqrt import rrps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  pix_tag_type           in_tag,
   input  logic [RADICAND_W-1:0] in_radicand,
   output pix_tag_type           out_tag,
   output logic [ROOT_W-1:0]     out_root
);

   pix_tag_type           tag_ff  [SQ_STAGES];
   logic [RADICAND_W-1:0] rad_ff  [SQ_STAGES];
   logic [ROOT_W-1:0]     root_ff [SQ_STAGES];
   logic [REM_W-1:0]      rem_ff  [SQ_STAGES];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      pix_tag_type           tag_src;
      logic [RADICAND_W-1:0] rad_src;
      logic [ROOT_W-1:0]     root_src;
      logic [REM_W-1:0]      rem_src;
      logic [RADICAND_W-1:0] rad_in;
      logic [ROOT_W-1:0]     root_in;
      logic [REM_W-1:0]      rem_in;

      if (s == 0) begin : g_first
         assign tag_src  = in_tag;
         assign rad_src  = in_radicand;
         assign root_src = '0;
         assign rem_src  = '0;
      end else begin : g_next
         assign tag_src  = tag_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign root_src = root_ff[s-1];
         assign rem_src  = rem_ff[s-1];
      end

      // restoring digit recurrence: bring down two radicand bits, try (4*root + 1)
      always_comb begin
         logic [REM_W-1:0]      rem;
         logic [REM_W-1:0]      rem_sh;
         logic [REM_W-1:0]      trial;
         logic [ROOT_W-1:0]     root;
         logic [RADICAND_W-1:0] rad;
         rem  = rem_src;
         root = root_src;
         rad  = rad_src;
         for (int j = 0; j < SQ_STEPS; j++) begin
            if (s * SQ_STEPS + j < SQ_ITER) begin
               rem_sh = {rem[REM_W-3:0], rad[RADICAND_W-1 -: 2]};
               trial  = {1'b0, root[ROOT_W-2:0], 2'b01};
               if (rem_sh >= trial) begin
                  rem  = rem_sh - trial;
                  root = {root[ROOT_W-2:0], 1'b1};
               end else begin
                  rem  = rem_sh;
                  root = {root[ROOT_W-2:0], 1'b0};
               end
               rad = {rad[RADICAND_W-3:0], 2'b00};
            end
         end
         rad_in  = rad;
         root_in = root;
         rem_in  = rem;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else begin
            tag_ff[s] <= tag_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[s]  <= rad_in;
         root_ff[s] <= root_in;
         rem_ff[s]  <= rem_in;
      end
   end

   assign out_tag  = tag_ff[SQ_STAGES-1];
   assign out_root = root_ff[SQ_STAGES-1];

   // floor sqrt leaves a remainder no larger than twice the root
   `RRPS_ASSERT_IMP(a_sq_rem_bound, tag_ff[SQ_STAGES-1].valid, (rem_ff[SQ_STAGES-1] <= {1'b0, root_ff[SQ_STAGES-1], 1'b0}))
   `RRPS_ASSERT_DLY(a_sq_valid_prop, in_tag.valid, SQ_STAGES, out_tag.valid)
   `RRPS_ASSERT_DLY(a_sq_idle_prop, !in_tag.valid, SQ_STAGES, !out_tag.valid)

endmodule

// ===== hdl/rounded_rect_pixel_shader.sv =====
// Top level of the anti-aliased rounded rectangle pixel shader.
// Depends on rrps_pkg and rrps_isqrt.
//
// Usage:
//  - Input: raise start with req_pix_x / req_pix_y. busy is always low, so a
//    transfer happens at every clock edge where start is high; one pixel may
//    enter on every cycle.
//  - Output: rsp_valid pulses for one cycle with rsp_pixel_bgra and
//    rsp_in_corner_zone. The receiver cannot stall, and none is needed:
//    results leave in input order, one per accepted pixel.
//  - Pipeline: a pixel passes the offset, square and sum stages, then the square
//    root pipeline, which resolves two result bits per stage over ten stages,
//    then the shade and output stages.
//  - Throughput: one pixel per clock, sustained.
//  - Configuration: csr_we / csr_index / csr_wdata write one register per
//    clock, no wait states. Write only while no pixel is in flight.
//  - Reset: synchronous; clears the pipeline valid bits and loads the register
//    defaults (64 x 32, radius 8, border 1, black fill, white border, opaque).
`include "rounded_rect_pixel_shader_assert.svh"

module rounded_rect_pixel_shader import rrps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [COORD_W-1:0]   req_pix_x,
   input  logic [COORD_W-1:0]   req_pix_y,
   output logic                 rsp_valid,
   output logic [PIXEL_W-1:0]   rsp_pixel_bgra,
   output logic                 rsp_in_corner_zone,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [2:0] MODE_CLEAR = 3'd0;
   localparam logic [2:0] MODE_FILL  = 3'd1;
   localparam logic [2:0] MODE_INNER = 3'd2;
   localparam logic [2:0] MODE_EDGE  = 3'd3;
   localparam logic [2:0] MODE_OUTER = 3'd4;

   localparam int TW = ROOT_W + 3;
   localparam logic signed [TW-1:0] HALF_Q = TW'(2 ** (DIST_FRAC_BITS - 1));
   localparam logic signed [TW-1:0] ONE_Q  = TW'(2 ** DIST_FRAC_BITS);
   localparam logic [COV_W-1:0]     COV_ONE = COV_W'(2 ** DIST_FRAC_BITS);

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0]    rect_width_ff;
   logic [DIM_W-1:0]    rect_height_ff;
   logic [RADIUS_W-1:0] corner_radius_ff;
   logic [RADIUS_W-1:0] border_width_ff;
   logic [RGB_W-1:0]    fill_rgb_ff;
   logic [CHAN_W-1:0]   fill_alpha_ff;
   logic [RGB_W-1:0]    edge_rgb_ff;
   logic [CHAN_W-1:0]   edge_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_width_ff    <= DIM_W'(64);
         rect_height_ff   <= DIM_W'(32);
         corner_radius_ff <= RADIUS_W'(8);
         border_width_ff  <= RADIUS_W'(1);
         fill_rgb_ff      <= '0;
         fill_alpha_ff    <= '1;
         edge_rgb_ff      <= '1;
         edge_alpha_ff    <= '1;
      end else if (csr_we) begin
         case (csr_index)
            REG_RECT_WIDTH:    rect_width_ff    <= csr_wdata[DIM_W-1:0];
            REG_RECT_HEIGHT:   rect_height_ff   <= csr_wdata[DIM_W-1:0];
            REG_CORNER_RADIUS: corner_radius_ff <= csr_wdata[RADIUS_W-1:0];
            REG_BORDER_WIDTH:  border_width_ff  <= csr_wdata[RADIUS_W-1:0];
            REG_FILL_RGB:      fill_rgb_ff      <= csr_wdata[RGB_W-1:0];
            REG_FILL_ALPHA:    fill_alpha_ff    <= csr_wdata[CHAN_W-1:0];
            REG_EDGE_RGB:      edge_rgb_ff      <= csr_wdata[RGB_W-1:0];
            REG_EDGE_ALPHA:    edge_alpha_ff    <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- stage 1: region select and corner offsets ----------------
   pix_tag_type      p1_tag_in, p1_tag_ff;
   logic [MAG_W-1:0] p1_dx_in, p1_dx_ff;
   logic [MAG_W-1:0] p1_dy_in, p1_dy_ff;

   always_comb begin
      logic [DIM_W-1:0]    w_sat;
      logic [DIM_W-1:0]    h_sat;
      logic signed [CW-1:0] xs, ys, ws, hs, rs, bs;
      logic signed [CW-1:0] dx_l, dx_r, dy_t, dy_b, dx, dy;
      logic left, right, top, bottom, outside, corner, use_left, use_top;
      w_sat = (rect_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_width_ff;
      h_sat = (rect_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_height_ff;
      xs = $signed(CW'(req_pix_x));
      ys = $signed(CW'(req_pix_y));
      ws = $signed(CW'(w_sat));
      hs = $signed(CW'(h_sat));
      rs = $signed(CW'(corner_radius_ff));
      bs = $signed(CW'(border_width_ff));

      outside = (xs >= ws) || (ys >= hs);
      left    = xs < rs;
      right   = xs >= ws - rs;
      top     = ys < rs;
      bottom  = ys >= hs - rs;

      // doubled offsets to the corner centers
      dx_l = xs + xs - rs - rs + CW'(1);
      dx_r = xs + xs - ws - ws + rs + rs + CW'(1);
      dy_t = ys + ys - rs - rs + CW'(1);
      dy_b = ys + ys - hs - hs + rs + rs + CW'(1);

      // first match wins: top-left, top-right, bottom-left, bottom-right
      corner   = 1'b1;
      use_left = 1'b1;
      use_top  = 1'b1;
      if (left && top) begin
         use_left = 1'b1;
         use_top  = 1'b1;
      end else if (right && top) begin
         use_left = 1'b0;
         use_top  = 1'b1;
      end else if (left && bottom) begin
         use_left = 1'b1;
         use_top  = 1'b0;
      end else if (right && bottom) begin
         use_left = 1'b0;
         use_top  = 1'b0;
      end else begin
         corner = 1'b0;
      end

      dx = use_left ? dx_l : dx_r;
      dy = use_top ? dy_t : dy_b;
      if (dx[CW-1]) dx = -dx;
      if (dy[CW-1]) dy = -dy;
      p1_dx_in = dx[MAG_W-1:0];
      p1_dy_in = dy[MAG_W-1:0];

      p1_tag_in.valid     = start && !busy;
      p1_tag_in.outside   = outside;
      p1_tag_in.corner    = corner && !outside;
      p1_tag_in.on_border = (ys < bs) || (ys >= hs - bs) || (xs < bs) || (xs >= ws - bs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
      end else begin
         p1_tag_ff <= p1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_dx_ff <= p1_dx_in;
      p1_dy_ff <= p1_dy_in;
   end

   // ---------------- stage 2: squares ----------------
   pix_tag_type      p2_tag_ff;
   logic [SQR_W-1:0] p2_sqx_in, p2_sqx_ff;
   logic [SQR_W-1:0] p2_sqy_in, p2_sqy_ff;

   assign p2_sqx_in = p1_dx_ff * p1_dx_ff;
   assign p2_sqy_in = p1_dy_ff * p1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_tag_ff <= '0;
      end else begin
         p2_tag_ff <= p1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_sqx_ff <= p2_sqx_in;
      p2_sqy_ff <= p2_sqy_in;
   end

   // ---------------- stage 3: squared distance, scaled for Q.F root ----------------
   pix_tag_type           p3_tag_ff;
   logic [D2_W-1:0]       p3_d2;
   logic [RADICAND_W-1:0] p3_rad_in, p3_rad_ff;

   assign p3_d2     = D2_W'(p2_sqx_ff) + D2_W'(p2_sqy_ff);
   assign p3_rad_in = RADICAND_W'({p3_d2, {SQ_SHIFT{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_tag_ff <= '0;
      end else begin
         p3_tag_ff <= p2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_rad_ff <= p3_rad_in;
   end

   // ---------------- root stages ----------------
   pix_tag_type       sq_tag;
   logic [ROOT_W-1:0] sq_root;

   rrps_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (p3_tag_ff),
      .in_radicand (p3_rad_ff),
      .out_tag     (sq_tag),
      .out_root    (sq_root)
   );

   // ---------------- shade stage: band select and coverage ----------------
   pix_tag_type      sh_tag_ff;
   logic [2:0]       sh_mode_in, sh_mode_ff;
   logic [COV_W-1:0] sh_cov_in, sh_cov_ff;

   function automatic logic [COV_W-1:0] clamp_cov(input logic signed [TW-1:0] v);
      logic [COV_W-1:0] c;
      if (v[TW-1]) begin
         c = '0;
      end else if (v > ONE_Q) begin
         c = COV_ONE;
      end else begin
         c = v[COV_W-1:0];
      end
      return c;
   endfunction

   always_comb begin
      logic signed [RADIUS_W:0] inner_px;
      logic signed [TW-1:0]     d_q, ro_q, ri_q;
      inner_px = $signed({1'b0, corner_radius_ff}) - $signed({1'b0, border_width_ff});
      d_q  = $signed(TW'(sq_root));
      ro_q = $signed(TW'({corner_radius_ff, {DIST_FRAC_BITS{1'b0}}}));
      ri_q = $signed({{(TW - RADIUS_W - 1 - DIST_FRAC_BITS){inner_px[RADIUS_W]}},
                      inner_px, {DIST_FRAC_BITS{1'b0}}});
      sh_cov_in = '0;
      if (sq_tag.outside) begin
         sh_mode_in = MODE_CLEAR;
      end else if (!sq_tag.corner) begin
         sh_mode_in = sq_tag.on_border ? MODE_EDGE : MODE_FILL;
      end else if (d_q <= ri_q - HALF_Q) begin
         sh_mode_in = MODE_FILL;
      end else if (d_q <= ri_q + HALF_Q) begin
         sh_mode_in = MODE_INNER;
         sh_cov_in  = clamp_cov(ri_q + HALF_Q - d_q);
      end else if (d_q <= ro_q - HALF_Q) begin
         sh_mode_in = MODE_EDGE;
      end else if (d_q <= ro_q + HALF_Q) begin
         sh_mode_in = MODE_OUTER;
         sh_cov_in  = clamp_cov(ro_q + HALF_Q - d_q);
      end else begin
         sh_mode_in = MODE_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_tag_ff <= '0;
      end else begin
         sh_tag_ff <= sq_tag;
      end
   end

   always_ff @(posedge clock) begin
      sh_mode_ff <= sh_mode_in;
      sh_cov_ff  <= sh_cov_in;
   end

   // ---------------- output stage: blend and pack ----------------
   logic              rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_pixel_in, rsp_pixel_ff;
   logic              rsp_corner_ff;

   function automatic logic [CHAN_W-1:0] mix(input logic [COV_W-1:0] cov,
                                             input logic [CHAN_W-1:0] f,
                                             input logic [CHAN_W-1:0] e);
      logic [COV_W+CHAN_W-1:0] acc;
      acc = cov * f + (COV_ONE - cov) * e;
      return acc[DIST_FRAC_BITS +: CHAN_W];
   endfunction

   always_comb begin
      logic [COV_W+CHAN_W-1:0] rim_alpha;
      logic [PIXEL_W-1:0]      blend;
      rim_alpha = sh_cov_ff * edge_alpha_ff;
      for (int c = 0; c < 3; c++) begin
         blend[c*CHAN_W +: CHAN_W] = mix(sh_cov_ff, fill_rgb_ff[c*CHAN_W +: CHAN_W],
                                         edge_rgb_ff[c*CHAN_W +: CHAN_W]);
      end
      blend[RGB_W +: CHAN_W] = mix(sh_cov_ff, fill_alpha_ff, edge_alpha_ff);
      case (sh_mode_ff)
         MODE_FILL:  rsp_pixel_in = {fill_alpha_ff, fill_rgb_ff};
         MODE_INNER: rsp_pixel_in = blend;
         MODE_EDGE:  rsp_pixel_in = {edge_alpha_ff, edge_rgb_ff};
         MODE_OUTER: rsp_pixel_in = {rim_alpha[DIST_FRAC_BITS +: CHAN_W], edge_rgb_ff};
         default:    rsp_pixel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sh_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_corner_ff <= sh_tag_ff.corner;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_bgra     = rsp_pixel_ff;
   assign rsp_in_corner_zone = rsp_corner_ff;

   `RRPS_ASSERT_DLY(a_rsp_follows_req, (start && !busy), PIPE_LAT, rsp_valid)
   `RRPS_ASSERT_DLY(a_no_rsp_without_req, !(start && !busy), PIPE_LAT, !rsp_valid)
   `RRPS_ASSERT_IMP(a_cov_bound, sh_tag_ff.valid, (sh_cov_ff <= COV_ONE))

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for rounded_rect_pixel_shader: random pixel coordinates and
// register settings, each result checked against a local shading model.
// Depends on rrps_pkg and the shader RTL only.
`timescale 1ns / 1ps

module testbench;
   import rrps_pkg::*;

   typedef enum logic {JOB_PIXEL, JOB_CSR} job_kind_type;

   typedef struct {
      job_kind_type       kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      csr_reg_type        idx;
      logic [CSR_W-1:0]   val;
   } job_type;

   typedef struct {
      logic [DIM_W-1:0]    rect_width;
      logic [DIM_W-1:0]    rect_height;
      logic [RADIUS_W-1:0] corner_radius;
      logic [RADIUS_W-1:0] border_width;
      logic [RGB_W-1:0]    fill_rgb;
      logic [CHAN_W-1:0]   fill_alpha;
      logic [RGB_W-1:0]    edge_rgb;
      logic [CHAN_W-1:0]   edge_alpha;
   } shape_cfg_type;

   typedef struct {
      logic [PIXEL_W-1:0] bgra;
      logic               corner;
   } shade_result_type;

   localparam longint ONE        = longint'(1) << DIST_FRAC_BITS;
   localparam longint HALF       = longint'(1) << (DIST_FRAC_BITS - 1);
   localparam int     QUIET_LIMIT = 2000;
   localparam int     CALM_TAIL  = 120;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [COORD_W-1:0]   req_pix_x = '0;
   logic [COORD_W-1:0]   req_pix_y = '0;
   logic                 rsp_valid;
   logic [PIXEL_W-1:0]   rsp_pixel_bgra;
   logic                 rsp_in_corner_zone;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   job_type          jobs[$];
   shade_result_type shaded_pixels_due[$];
   shape_cfg_type    cfg;
   int               error_count = 0;
   int               gap_left = 0;
   int               burst_pct = 20;
   int               pixels_sent = 0;
   int               quiet_cycles = 0;

   rounded_rect_pixel_shader dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_pix_x          (req_pix_x),
      .req_pix_y          (req_pix_y),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_bgra     (rsp_pixel_bgra),
      .rsp_in_corner_zone (rsp_in_corner_zone),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- shading model

   function automatic void apply_write(input csr_reg_type idx, input logic [CSR_W-1:0] val);
      case (idx)
         REG_RECT_WIDTH:    cfg.rect_width    = val[DIM_W-1:0];
         REG_RECT_HEIGHT:   cfg.rect_height   = val[DIM_W-1:0];
         REG_CORNER_RADIUS: cfg.corner_radius = val[RADIUS_W-1:0];
         REG_BORDER_WIDTH:  cfg.border_width  = val[RADIUS_W-1:0];
         REG_FILL_RGB:      cfg.fill_rgb      = val[RGB_W-1:0];
         REG_FILL_ALPHA:    cfg.fill_alpha    = val[CHAN_W-1:0];
         REG_EDGE_RGB:      cfg.edge_rgb      = val[RGB_W-1:0];
         REG_EDGE_ALPHA:    cfg.edge_alpha    = val[CHAN_W-1:0];
         default: ;
      endcase
   endfunction

   // floor(sqrt(v)) by bisection
   function automatic longint root_floor(input longint v);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = longint'(1) << 24;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint coverage(input longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
   endfunction

   // colour of a corner pixel at distance d (Q.8) from the corner center
   function automatic logic [PIXEL_W-1:0] corner_shade(input longint d);
      longint             r;
      longint             bw;
      longint             outer;
      longint             inner;
      longint             cov;
      longint             lane_v;
      logic [PIXEL_W-1:0] fill_px;
      logic [PIXEL_W-1:0] edge_px;
      logic [PIXEL_W-1:0] mixed;
      r = cfg.corner_radius;
      bw = cfg.border_width;
      outer = r * ONE;
      inner = (r - bw) * ONE;
      fill_px = {cfg.fill_alpha, cfg.fill_rgb};
      edge_px = {cfg.edge_alpha, cfg.edge_rgb};
      if (d <= inner - HALF) return fill_px;
      if (d <= inner + HALF) begin
         cov = coverage(inner + HALF - d);
         for (int k = 0; k < 4; k++) begin
            lane_v = (cov * longint'(fill_px[8*k +: 8])
                      + (ONE - cov) * longint'(edge_px[8*k +: 8])) >> DIST_FRAC_BITS;
            mixed[8*k +: 8] = lane_v[7:0];
         end
         return mixed;
      end
      if (d <= outer - HALF) return edge_px;
      if (d <= outer + HALF) begin
         cov = coverage(outer + HALF - d);
         lane_v = (cov * longint'(cfg.edge_alpha)) >> DIST_FRAC_BITS;
         return {lane_v[7:0], cfg.edge_rgb};
      end
      return '0;
   endfunction

   function automatic shade_result_type shade_pixel(input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] py);
      longint           x;
      longint           y;
      longint           w;
      longint           h;
      longint           r;
      longint           bw;
      longint           dx2;
      longint           dy2;
      shade_result_type res;
      x = px;
      y = py;
      w = cfg.rect_width;
      h = cfg.rect_height;
      if (w > MAX_DIM) w = MAX_DIM;
      if (h > MAX_DIM) h = MAX_DIM;
      r = cfg.corner_radius;
      bw = cfg.border_width;
      res.bgra = '0;
      res.corner = 1'b0;
      if (x >= w || y >= h) return res;
      // doubled offsets to the corner center; first matching corner wins
      res.corner = 1'b1;
      if (x < r && y < r) begin
         dx2 = 2 * x - (2 * r - 1);
         dy2 = 2 * y - (2 * r - 1);
      end else if (x >= w - r && y < r) begin
         dx2 = 2 * x - (2 * w - 2 * r - 1);
         dy2 = 2 * y - (2 * r - 1);
      end else if (x < r && y >= h - r) begin
         dx2 = 2 * x - (2 * r - 1);
         dy2 = 2 * y - (2 * h - 2 * r - 1);
      end else if (x >= w - r && y >= h - r) begin
         dx2 = 2 * x - (2 * w - 2 * r - 1);
         dy2 = 2 * y - (2 * h - 2 * r - 1);
      end else begin
         res.corner = 1'b0;
      end
      if (res.corner)
         res.bgra = corner_shade(root_floor((dx2 * dx2 + dy2 * dy2) << SQ_SHIFT));
      else if (y < bw || y >= h - bw || x < bw || x >= w - bw)
         res.bgra = {cfg.edge_alpha, cfg.edge_rgb};
      else
         res.bgra = {cfg.fill_alpha, cfg.fill_rgb};
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus plan

   task automatic queue_pixel(input int x, input int y);
      job_type j;
      j.kind = JOB_PIXEL;
      j.x = x[COORD_W-1:0];
      j.y = y[COORD_W-1:0];
      j.idx = REG_RECT_WIDTH;
      j.val = '0;
      jobs.push_back(j);
   endtask

   task automatic queue_write(input csr_reg_type idx, input logic [CSR_W-1:0] val);
      job_type j;
      j.kind = JOB_CSR;
      j.x = '0;
      j.y = '0;
      j.idx = idx;
      j.val = val;
      jobs.push_back(j);
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   // coordinate within span of either end of [0, extent)
   function automatic int near_end(input int extent, input int span);
      int off;
      off = $urandom_range(0, span);
      if ($urandom_range(0, 1)) return clamp_coord(off);
      return clamp_coord(extent - 1 - off);
   endfunction

   function automatic int anywhere_in(input int extent);
      if (extent < 1) return $urandom_range(0, 1023);
      return clamp_coord($urandom_range(0, extent - 1));
   endfunction

   task automatic queue_pixels(input int n, input int w, input int h, input int r,
                               input int bw);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50)
            queue_pixel(near_end(w, r + 2), near_end(h, r + 2));
         else if (sel < 60)
            queue_pixel(near_end(w, bw + 2), anywhere_in(h));
         else if (sel < 70)
            queue_pixel(anywhere_in(w), near_end(h, bw + 2));
         else if (sel < 90)
            queue_pixel(anywhere_in(w), anywhere_in(h));
         else
            queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   task automatic queue_phase(input int w, input int h, input int r, input int bw,
                              input logic [RGB_W-1:0] fill, input logic [CHAN_W-1:0] fa,
                              input logic [RGB_W-1:0] border, input logic [CHAN_W-1:0] ea,
                              input int n);
      queue_write(REG_RECT_WIDTH, CSR_W'(w));
      queue_write(REG_RECT_HEIGHT, CSR_W'(h));
      queue_write(REG_CORNER_RADIUS, CSR_W'(r));
      queue_write(REG_BORDER_WIDTH, CSR_W'(bw));
      queue_write(REG_FILL_RGB, fill);
      queue_write(REG_FILL_ALPHA, CSR_W'(fa));
      queue_write(REG_EDGE_RGB, border);
      queue_write(REG_EDGE_ALPHA, CSR_W'(ea));
      queue_pixels(n, (w > MAX_DIM) ? MAX_DIM : w, (h > MAX_DIM) ? MAX_DIM : h, r, bw);
   endtask

   function automatic logic [CHAN_W-1:0] pick_alpha();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int w;
      int h;
      int r;
      int bw;
      // reset shape (64 x 32, radius 8, border 1): corners, ring, rim, edges, outside
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(63, 0);
      queue_pixel(0, 31);
      queue_pixel(63, 31);
      queue_pixel(7, 7);
      queue_pixel(1, 1);
      queue_pixel(2, 2);
      queue_pixel(1, 2);
      queue_pixel(3, 3);
      queue_pixel(2, 3);
      queue_pixel(56, 2);
      queue_pixel(3, 27);
      queue_pixel(60, 29);
      queue_pixel(32, 0);
      queue_pixel(0, 16);
      queue_pixel(32, 16);
      queue_pixel(8, 8);
      queue_pixel(64, 5);
      queue_pixel(5, 32);

      // extreme settings: largest shape, one pixel, overlapping corners,
      // saturated size with full-width fields, zero width, border thicker than radius
      queue_phase(1024, 1024, 512, 512, 24'hFFFFFF, 8'h00, 24'h000000, 8'hFF, 119);
      queue_phase(1, 1, 0, 0, RGB_W'($urandom), pick_alpha(), RGB_W'($urandom),
                  pick_alpha(), 119);
      queue_phase(1024, 16, 512, 3, RGB_W'($urandom), 8'hFF, RGB_W'($urandom), 8'h80,
                  119);
      queue_phase(2047, 2047, 1023, 1023, RGB_W'($urandom), pick_alpha(),
                  RGB_W'($urandom), pick_alpha(), 119);
      queue_phase(0, 100, 10, 2, RGB_W'($urandom), 8'hFF, RGB_W'($urandom), 8'hFF, 119);
      queue_phase(40, 1024, 20, 25, RGB_W'($urandom), pick_alpha(), RGB_W'($urandom),
                  pick_alpha(), 119);
      for (int p = 0; p < 6; p++) begin
         w = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
         h = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
         r = $urandom_range(0, ((w < h ? w : h) + 8) / 2);
         bw = $urandom_range(0, r + 4);
         queue_phase(w, h, r, bw, RGB_W'($urandom), pick_alpha(), RGB_W'($urandom),
                     pick_alpha(), 119);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (jobs.size() != 0 || start || csr_we || shaded_pixels_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
      if (error_count == 0 && shaded_pixels_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      job_type head;
      logic nxt_start;
      logic nxt_we;
      if (reset) begin
         cfg.rect_width = 11'd64;
         cfg.rect_height = 11'd32;
         cfg.corner_radius = 10'd8;
         cfg.border_width = 10'd1;
         cfg.fill_rgb = 24'h000000;
         cfg.fill_alpha = 8'hFF;
         cfg.edge_rgb = 24'hFFFFFF;
         cfg.edge_alpha = 8'hFF;
         gap_left = 0;
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         if (csr_we) apply_write(csr_reg_type'(csr_index), csr_wdata);
         if (start && !busy) begin
            shaded_pixels_due.push_back(shade_pixel(req_pix_x, req_pix_y));
            pixels_sent++;
            if (pixels_sent % 64 == 0) begin
               case ($urandom_range(0, 2))
                  0:       burst_pct = 0;
                  1:       burst_pct = 15;
                  default: burst_pct = 40;
               endcase
            end
         end
         nxt_start = start && busy;
         nxt_we = 1'b0;
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (jobs.size() != 0) begin
               head = jobs[0];
               if (head.kind == JOB_PIXEL) begin
                  nxt_start = 1'b1;
                  req_pix_x <= head.x;
                  req_pix_y <= head.y;
                  void'(jobs.pop_front());
                  if (jobs.size() > CALM_TAIL && $urandom_range(0, 99) < burst_pct)
                     gap_left = $urandom_range(1, 7);
               end else if (shaded_pixels_due.size() == 0 && !rsp_valid && !start) begin
                  // registers change only with the pipeline empty
                  nxt_we = 1'b1;
                  csr_index <= head.idx;
                  csr_wdata <= head.val;
                  void'(jobs.pop_front());
               end
            end
         end
         start <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      shade_result_type want;
      if (!reset && rsp_valid) begin
         if (shaded_pixels_due.size() == 0) begin
            $display("%0t: unexpected result transfer: pixel %08h corner %0b", $time,
                     rsp_pixel_bgra, rsp_in_corner_zone);
            error_count++;
         end else begin
            want = shaded_pixels_due.pop_front();
            if (rsp_pixel_bgra !== want.bgra) begin
               $display("%0t: pixel_bgra mismatch: expected %08h, actual %08h", $time,
                        want.bgra, rsp_pixel_bgra);
               error_count++;
            end
            if (rsp_in_corner_zone !== want.corner) begin
               $display("%0t: in_corner_zone mismatch: expected %0b, actual %0b", $time,
                        want.corner, rsp_in_corner_zone);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== rounded_rect_pixel_shader.f =====
+incdir+hdl
hdl/rrps_pkg.sv
hdl/rrps_isqrt.sv
hdl/rounded_rect_pixel_shader.sv
sim/testbench.sv
